### hdl/sha1md_pkg.sv
// Shared types, codes and constants of the SHA-1 message digest unit.
// Depends on nothing; sha1md_dp, sha1md_ctrl and the top level import it.
package sha1md_pkg;

	localparam int unsigned WORDS = 5;
	localparam int unsigned SCHED_WORDS = 16;
	localparam int unsigned ROUNDS = 80;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'(WORDS - 1);

	typedef logic [1:0] byte_sel_t;
	localparam byte_sel_t SEL_INPUT = 2'd0;
	localparam byte_sel_t SEL_PAD = 2'd1;
	localparam byte_sel_t SEL_ZERO = 2'd2;
	localparam byte_sel_t SEL_LEN = 2'd3;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_CH = 2'd0;
	localparam phase_t PH_PAR1 = 2'd1;
	localparam phase_t PH_MAJ = 2'd2;
	localparam phase_t PH_PAR2 = 2'd3;

	typedef struct packed {
		logic wr_byte;
		byte_sel_t byte_sel;
		logic cnt_inc;
		logic load_work;
		logic round_en;
		phase_t phase;
		logic add_hash;
		logic restart;
		logic [2:0] word_sel;
	} sha1md_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} sha1md_stat_t;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] v;
		unique case (idx)
			3'd0: v = 32'h67452301;
			3'd1: v = 32'hEFCDAB89;
			3'd2: v = 32'h98BADCFE;
			3'd3: v = 32'h10325476;
			default: v = 32'hC3D2E1F0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input phase_t ph);
		logic [31:0] v;
		unique case (ph)
			PH_CH: v = 32'h5A827999;
			PH_PAR1: v = 32'h6ED9EBA1;
			PH_MAJ: v = 32'h8F1BBCDC;
			default: v = 32'hCA62C1D6;
		endcase
		return v;
	endfunction

endpackage

### hdl/sha1md_if.sv
// Valid/ready channel interfaces of the SHA-1 message digest unit.
// Message bytes come in on sha1md_in_if, digest words leave on sha1md_out_if.
interface sha1md_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic byte_valid;
	logic end_of_message;

	modport source(output valid, output data_byte, output byte_valid,
		output end_of_message, input ready);
	modport sink(input valid, input data_byte, input byte_valid,
		input end_of_message, output ready);
endinterface

interface sha1md_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	modport source(output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink(input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

### hdl/sha1md_dp.sv
// Datapath of the SHA-1 unit: chaining words, working variables, the
// 16-word block/schedule window, fill position and byte count. Uses sha1md_pkg.
module sha1md_dp import sha1md_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input sha1md_cmd_t cmd,
	output sha1md_stat_t stat,
	output logic [31:0] digest_word
);

	logic [31:0] h_q [WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [SCHED_WORDS];
	logic [5:0] pos_q;
	logic [60:0] count_q;

	logic [63:0] bit_len;
	logic [7:0] len_byte;
	logic [7:0] byte_d;
	logic [31:0] f_d;
	logic [31:0] t_d;
	logic [31:0] x_d;
	logic [31:0] w_new;

	assign bit_len = {count_q, 3'b000};
	assign len_byte = 8'(bit_len >> {~pos_q[2:0], 3'b000});

	always_comb begin
		case (cmd.byte_sel)
			SEL_INPUT: byte_d = data_byte;
			SEL_PAD: byte_d = PAD_BYTE;
			SEL_ZERO: byte_d = 8'h00;
			default: byte_d = len_byte;
		endcase
	end

	always_comb begin
		case (cmd.phase)
			PH_CH: f_d = (b_q & c_q) | (~b_q & d_q);
			PH_MAJ: f_d = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f_d = b_q ^ c_q ^ d_q;
		endcase
	end

	assign t_d = {a_q[26:0], a_q[31:27]} + f_d + e_q + round_k(cmd.phase) + w_q[0];
	assign x_d = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {x_d[30:0], x_d[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) h_q[i] <= h_init(3'(i));
			pos_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.wr_byte) pos_q <= pos_q + 6'd1;
			if (cmd.cnt_inc) count_q <= count_q + 61'd1;
			if (cmd.add_hash) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.restart) begin
				for (int i = 0; i < WORDS; i++) h_q[i] <= h_init(3'(i));
				pos_q <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++)
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			w_q[SCHED_WORDS - 1] <= {w_q[SCHED_WORDS - 1][23:0], byte_d};
		end else if (cmd.round_en) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++) w_q[i] <= w_q[i + 1];
			w_q[SCHED_WORDS - 1] <= w_new;
		end
		if (cmd.load_work) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_d;
		end
	end

	always_comb begin
		case (cmd.word_sel)
			3'd0: digest_word = h_q[0];
			3'd1: digest_word = h_q[1];
			3'd2: digest_word = h_q[2];
			3'd3: digest_word = h_q[3];
			default: digest_word = h_q[4];
		endcase
	end

	assign stat.pos = pos_q;

endmodule

### hdl/sha1md_ctrl.sv
// Controller of the SHA-1 unit: byte intake, padding sequence, round
// counter and digest output. Uses sha1md_pkg; drives sha1md_dp by commands.
module sha1md_ctrl import sha1md_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic byte_valid,
	input logic end_of_message,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] word_index,
	output logic last_word,
	input sha1md_stat_t stat,
	output sha1md_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD = 3'd1;
	localparam logic [2:0] S_ZERO = 3'd2;
	localparam logic [2:0] S_LEN = 3'd3;
	localparam logic [2:0] S_COMP = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS);
	localparam logic [6:0] PH1_START = 7'(ROUNDS / 4);
	localparam logic [6:0] PH2_START = 7'(ROUNDS / 2);
	localparam logic [6:0] PH3_START = 7'(3 * ROUNDS / 4);

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] idx_q, idx_d;
	logic in_fire;
	logic wrap;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign word_index = idx_q;
	assign last_word = (idx_q == LAST_IDX);
	assign in_fire = in_valid & in_ready;
	assign wrap = (stat.pos == LAST_POS);

	always_comb begin
		cmd = '0;
		cmd.byte_sel = SEL_INPUT;
		cmd.word_sel = idx_q;
		if (rnd_q < PH1_START) cmd.phase = PH_CH;
		else if (rnd_q < PH2_START) cmd.phase = PH_PAR1;
		else if (rnd_q < PH3_START) cmd.phase = PH_MAJ;
		else cmd.phase = PH_PAR2;
		state_d = state_q;
		ret_d = ret_q;
		rnd_d = rnd_q;
		idx_d = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.wr_byte = byte_valid;
					cmd.cnt_inc = byte_valid;
					if (byte_valid && wrap) begin
						cmd.load_work = 1'b1;
						rnd_d = '0;
						state_d = S_COMP;
						ret_d = end_of_message ? S_PAD : S_IDLE;
					end else if (end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.wr_byte = 1'b1;
				cmd.byte_sel = SEL_PAD;
				if (wrap) begin
					cmd.load_work = 1'b1;
					rnd_d = '0;
					state_d = S_COMP;
					ret_d = S_ZERO;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_ZERO: begin
				cmd.wr_byte = 1'b1;
				if (stat.pos == LEN_POS) begin
					cmd.byte_sel = SEL_LEN;
					state_d = S_LEN;
				end else begin
					cmd.byte_sel = SEL_ZERO;
					if (wrap) begin
						cmd.load_work = 1'b1;
						rnd_d = '0;
						state_d = S_COMP;
						ret_d = S_ZERO;
					end
				end
			end
			S_LEN: begin
				cmd.wr_byte = 1'b1;
				cmd.byte_sel = SEL_LEN;
				if (wrap) begin
					cmd.load_work = 1'b1;
					rnd_d = '0;
					state_d = S_COMP;
					ret_d = S_OUT;
				end
			end
			S_COMP: begin
				if (rnd_q == LAST_ROUND) begin
					cmd.add_hash = 1'b1;
					state_d = ret_q;
				end else begin
					cmd.round_en = 1'b1;
					rnd_d = rnd_q + 7'd1;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (idx_q == LAST_IDX) begin
						cmd.restart = 1'b1;
						idx_d = '0;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			rnd_q <= rnd_d;
			idx_q <= idx_d;
		end
	end

endmodule

### hdl/sha1_message_digest_unit.sv
// SHA-1 digest of a byte stream. Message bytes are taken one per cycle; when
// the 64th byte of a block lands, input stalls while the single round unit
// runs the 80 rounds and the chaining add. An end-of-message transfer starts
// padding at one byte per cycle (one block, or two when fewer than nine bytes
// of the block are free, each followed by its compression), then five digest
// word transfers, most significant first. Input stays stalled until the last
// word is taken; the unit then starts over from the initial hash values.
// Uses sha1md_pkg and sha1md_if; instantiates sha1md_ctrl and sha1md_dp.
module sha1_message_digest_unit import sha1md_pkg::*; (
	input logic clk,
	input logic arst_n,
	sha1md_in_if.sink message,
	sha1md_out_if.source digest
);

	sha1md_cmd_t cmd;
	sha1md_stat_t stat;

	sha1md_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(message.valid),
		.byte_valid(message.byte_valid),
		.end_of_message(message.end_of_message),
		.in_ready(message.ready),
		.out_valid(digest.valid),
		.out_ready(digest.ready),
		.word_index(digest.word_index),
		.last_word(digest.last_word),
		.stat(stat),
		.cmd(cmd)
	);

	sha1md_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(message.data_byte),
		.cmd(cmd),
		.stat(stat),
		.digest_word(digest.digest_word)
	);

endmodule

### hdl/sha1md_checker.sv
// Port-level checks of the SHA-1 message digest unit, bound to the top level.
// Depends on sha1_message_digest_unit and its channel interfaces.
module sha1md_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] digest_word,
	input logic [2:0] word_index,
	input logic last_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) &&
		$stable(word_index))
		else $error("digest word changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word does not match word_index");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
		out_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest words out of order");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid && in_ready)
		else $error("unit did not return to idle after the digest");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while the digest is being sent");

endmodule

bind sha1_message_digest_unit sha1md_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(message.ready),
	.out_valid(digest.valid),
	.out_ready(digest.ready),
	.digest_word(digest.digest_word),
	.word_index(digest.word_index),
	.last_word(digest.last_word)
);
